### design/ssh_pkg.sv
`default_nettype none
package ssh_pkg;

  localparam int CAPACITY_DEF = 256;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes carried on the output tuser.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_BAD_FIRST = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_BUCKET_MODE  = 2'd0;
  localparam logic [1:0] REG_FIRST_BUCKET = 2'd1;
  localparam logic [1:0] REG_BUCKET_SIZE  = 2'd2;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

### design/sparse_sorted_histogram.sv
// An add scans up to N entries for the value's slot and shifts up to N entries up by
// one; a bucket-mode summary adds a serial divide; a bucket read adds a serial multiply
// and a walk of the table; a bucket-mode largest query walks the table with one divide
// per new bucket. N is the fill of the table.
// A new item is taken only in the idle state, after the last result is loaded for output.
// Reset (synchronous, rst high) empties the table and sets the registers to 0, 0, 1.
`default_nettype none
module sparse_sorted_histogram #(
  parameter int CAPACITY = ssh_pkg::CAPACITY_DEF,
  localparam int AW  = $clog2(CAPACITY),
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int ODW = 32 + 32 + CW + 32 + 32 + 33,
  localparam int ODP = ((ODW + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  // Fields from bit 0: sample_value[31:0], add_count[63:32], read_index[95:64].
  input  wire logic [95:0]     s_tdata,
  // Fields: kind.
  input  wire logic [1:0]      s_tuser,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  // Fields from bit 0: entry_value(32), entry_count(32), distinct_count(CW),
  // min_value(32), max_value(32), bucket_total(33), zero fill to whole bytes.
  output logic [ODP-1:0]       m_tdata,
  // Fields: status.
  output logic [1:0]           m_tuser,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [31:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_ADD_DEC, S_SHIFT_RD, S_SHIFT_WR,
    S_SUMMARY, S_DIV, S_TOTAL, S_DISPATCH, S_SLOT_GET, S_MUL, S_BASE,
    S_WALK_RD, S_WALK_CHK, S_NEWB, S_OUT
  } state_t;

  // Configuration registers.
  logic               bucket_mode;
  logic signed [31:0] first_bucket;
  logic [30:0]        bucket_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_mode  <= 1'b0;
      first_bucket <= '0;
      bucket_size  <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        ssh_pkg::REG_BUCKET_MODE:  bucket_mode  <= cfg_data[0];
        ssh_pkg::REG_FIRST_BUCKET: first_bucket <= cfg_data;
        ssh_pkg::REG_BUCKET_SIZE:  bucket_size  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // A zero bucket size behaves as one.
  logic [30:0] eff_size;
  assign eff_size = (bucket_size == 31'd0) ? 31'd1 : bucket_size;

  // The table: one word per entry, frequency above value, kept sorted by value.
  logic [63:0] mem [CAPACITY];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;
  logic        wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Control and working registers.
  state_t             state, div_ret;
  logic [CW-1:0]      used, idx, pos;
  logic [1:0]         kind;
  logic signed [31:0] sval;
  logic [31:0]        cnt, rdi, hit_f;
  logic               found;
  logic signed [31:0] min_value, max_value;
  logic [1:0]         status;
  logic signed [31:0] evalue;
  logic [31:0]        ecount, run, cur_f;
  logic signed [31:0] cur_v;
  logic [32:0]        total;
  logic [5:0]         step;
  // Serial divide and multiply share only the step counter; each has its own registers.
  logic [32:0]        dv_quo;
  logic [30:0]        dv_rem;
  logic [31:0]        mq;
  logic [33:0]        acc;
  logic signed [33:0] lower, upper, bend;

  logic [CW-1:0] idx_m1;
  assign idx_m1 = idx - CW'(1);

  logic signed [31:0] rd_v;
  logic [31:0]        rd_f;
  logic signed [33:0] rd_v34;
  assign rd_v   = rd_data[31:0];
  assign rd_f   = rd_data[63:32];
  assign rd_v34 = 34'(rd_v);

  logic bad_first;
  assign bad_first = first_bucket > min_value;

  // One restoring divide step.
  logic [31:0] trial;
  logic        ge;
  assign trial = {dv_rem, dv_quo[32]};
  assign ge    = trial >= {1'b0, eff_size};

  logic [31:0] run_n;
  assign run_n = ssh_pkg::sat_add(run, rd_f);

  always_comb begin
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = {cnt, sval};
    case (state)
      S_SHIFT_RD: rd_addr = idx_m1[AW-1:0];
      S_DISPATCH: rd_addr = rdi[AW-1:0];
      S_ADD_DEC: begin
        wr_en   = found;
        wr_data = {ssh_pkg::sat_add(hit_f, cnt), sval};
      end
      default: ;
    endcase
    if (state == S_SHIFT_RD && idx == pos) begin
      wr_en = 1'b1;
    end
    if (state == S_SHIFT_WR) begin
      wr_en   = 1'b1;
      wr_addr = idx[AW-1:0];
      wr_data = rd_data;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      min_value <= '0;
      max_value <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // Outside S_OUT a taken result clears valid; in S_OUT the new result is loaded in its place.
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind   <= s_tuser;
            sval   <= s_tdata[31:0];
            cnt    <= s_tdata[63:32];
            rdi    <= s_tdata[95:64];
            status <= ssh_pkg::ST_OK;
            evalue <= '0;
            ecount <= '0;
            idx    <= '0;
            found  <= 1'b0;
            state  <= (s_tuser == ssh_pkg::KIND_ADD) ? S_SRCH_RD : S_SUMMARY;
          end
        end
        S_SRCH_RD: begin
          if (idx == used) begin
            pos   <= used;
            state <= S_ADD_DEC;
          end else begin
            state <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (rd_v >= sval) begin
            pos   <= idx;
            hit_f <= rd_f;
            found <= (rd_v == sval);
            state <= S_ADD_DEC;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SRCH_RD;
          end
        end
        S_ADD_DEC: begin
          if (found) begin
            evalue <= sval;
            ecount <= ssh_pkg::sat_add(hit_f, cnt);
            state  <= S_SUMMARY;
          end else if (used == CW'(CAPACITY)) begin
            status <= ssh_pkg::ST_FULL;
            state  <= S_SUMMARY;
          end else begin
            idx   <= used;
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (idx == pos) begin
            // The new entry lands in its slot in this cycle.
            if (pos == '0) min_value <= sval;
            if (pos == used) max_value <= sval;
            used   <= used + CW'(1);
            evalue <= sval;
            ecount <= cnt;
            state  <= S_SUMMARY;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx_m1;
          state <= S_SHIFT_RD;
        end
        S_SUMMARY: begin
          if (!bucket_mode) begin
            total <= 33'(used);
            state <= S_DISPATCH;
          end else if (bad_first) begin
            total <= '0;
            state <= S_DISPATCH;
          end else begin
            dv_quo  <= 33'(max_value) - 33'(first_bucket);
            dv_rem  <= '0;
            step    <= '0;
            div_ret <= S_TOTAL;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          dv_rem <= ge ? 31'(trial - {1'b0, eff_size}) : trial[30:0];
          dv_quo <= {dv_quo[31:0], ge};
          step   <= step + 6'd1;
          if (step == 6'd32) state <= div_ret;
        end
        S_TOTAL: begin
          total <= dv_quo + 33'd1;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          idx <= '0;
          case (kind)
            ssh_pkg::KIND_READ: begin
              if (!bucket_mode) begin
                if (rdi < 32'(used)) begin
                  state <= S_SLOT_GET;
                end else begin
                  status <= ssh_pkg::ST_RANGE;
                  state  <= S_OUT;
                end
              end else if (bad_first) begin
                status <= ssh_pkg::ST_BAD_FIRST;
                state  <= S_OUT;
              end else if ({1'b0, rdi} >= total) begin
                status <= ssh_pkg::ST_RANGE;
                state  <= S_OUT;
              end else begin
                mq    <= rdi;
                acc   <= '0;
                step  <= '0;
                state <= S_MUL;
              end
            end
            ssh_pkg::KIND_QUERY: begin
              if (!bucket_mode) begin
                if (used == '0) begin
                  ecount <= 32'd1;
                  state  <= S_OUT;
                end else begin
                  state <= S_WALK_RD;
                end
              end else if (bad_first) begin
                status <= ssh_pkg::ST_BAD_FIRST;
                state  <= S_OUT;
              end else begin
                run   <= '0;
                state <= S_WALK_RD;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_SLOT_GET: begin
          evalue <= rd_v;
          ecount <= rd_f;
          state  <= S_OUT;
        end
        S_MUL: begin
          acc  <= {acc[32:0], 1'b0} + (mq[31] ? 34'(eff_size) : 34'd0);
          mq   <= {mq[30:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'd31) state <= S_BASE;
        end
        S_BASE: begin
          lower  <= 34'(first_bucket) + acc;
          upper  <= 34'(first_bucket) + acc + 34'(eff_size);
          evalue <= 32'(34'(first_bucket) + acc);
          state  <= S_WALK_RD;
        end
        S_WALK_RD: begin
          state <= (idx == used) ? S_OUT : S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (kind == ssh_pkg::KIND_READ) begin
            idx   <= idx + CW'(1);
            state <= S_WALK_RD;
            if (rd_v34 >= lower && rd_v34 < upper) ecount <= ssh_pkg::sat_add(ecount, rd_f);
          end else if (!bucket_mode) begin
            idx   <= idx + CW'(1);
            state <= S_WALK_RD;
            if (rd_f > ecount) ecount <= rd_f;
          end else if (idx == '0 || rd_v34 >= bend) begin
            // Entry opens a new bucket: its remainder gives the bucket end.
            cur_v   <= rd_v;
            cur_f   <= rd_f;
            dv_quo  <= 33'(rd_v) - 33'(first_bucket);
            dv_rem  <= '0;
            step    <= '0;
            div_ret <= S_NEWB;
            state   <= S_DIV;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_WALK_RD;
            run   <= run_n;
            if (run_n > ecount) ecount <= run_n;
          end
        end
        S_NEWB: begin
          bend <= 34'(cur_v) - 34'(dv_rem) + 34'(eff_size);
          run  <= cur_f;
          if (cur_f > ecount) ecount <= cur_f;
          idx   <= idx + CW'(1);
          state <= S_WALK_RD;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= ODP'({total, max_value, min_value, used, ecount, evalue});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill never passes capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) used <= CW'(CAPACITY))
    else $error("table fill above capacity");

  // One item inserts at most one entry.
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (used == $past(used) || used == $past(used) + CW'(1)))
    else $error("table fill changed by more than one");

  // A filled table keeps its smallest value at or below its largest.
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    used != '0 |-> min_value <= max_value)
    else $error("minimum above maximum");

endmodule
`default_nettype wire

### test/tb_sparse_sorted_histogram.sv
`default_nettype none
module tb_sparse_sorted_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = ssh_pkg::CAPACITY_DEF;
  localparam int ODP = 176;
  localparam longint LIMIT = 64'd25_000_000;

  // One result of the histogram, unpacked from the output stream.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_value;
    logic [31:0] entry_count;
    logic [8:0]  distinct_count;
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [32:0] bucket_total;
  } hist_result_t;

  // The scoreboard keeps its own copy of the sorted table and the register
  // settings, works out the result of every accepted transfer, and compares
  // results from the block in order.
  class histogram_scoreboard;
    int               tbl_values[CAP];
    logic [31:0]      tbl_freqs[CAP];
    int               fill;
    bit               bmode;
    int               first_val;
    logic [30:0]      bsize;
    hist_result_t     pending[$];
    int               mismatches;

    function void clear();
      fill = 0;
      bmode = 0;
      first_val = 0;
      bsize = 1;
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        ssh_pkg::REG_BUCKET_MODE: begin
          bmode = data[0];
        end
        ssh_pkg::REG_FIRST_BUCKET: begin
          first_val = data;
        end
        ssh_pkg::REG_BUCKET_SIZE: begin
          bsize = data[30:0];
        end
        default: ;
      endcase
    endfunction

    function longint width_of();
      return (bsize == 0) ? 64'd1 : longint'(bsize);
    endfunction

    function longint bucket_number(int v);
      return (longint'(v) - longint'(first_val)) / width_of();
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Notes one accepted input transfer and queues the result it implies.
    function void note_input(logic [1:0] kind, int sval, logic [31:0] cnt,
                             logic [31:0] idx);
      hist_result_t r;
      int pos;
      int minv;
      int maxv;
      bit bad_first;
      longint total;
      logic [31:0] run;
      r = '0;
      if (kind == ssh_pkg::KIND_ADD) begin
        pos = fill;
        for (int i = 0; i < fill; i++) begin
          if (tbl_values[i] >= sval) begin
            pos = i;
            break;
          end
        end
        if (pos < fill && tbl_values[pos] == sval) begin
          tbl_freqs[pos] = add_sat(tbl_freqs[pos], cnt);
          r.entry_value = sval;
          r.entry_count = tbl_freqs[pos];
        end else if (fill >= CAP) begin
          r.status = ssh_pkg::ST_FULL;
        end else begin
          for (int i = fill; i > pos; i--) begin
            tbl_values[i] = tbl_values[i-1];
            tbl_freqs[i] = tbl_freqs[i-1];
          end
          tbl_values[pos] = sval;
          tbl_freqs[pos] = cnt;
          fill++;
          r.entry_value = sval;
          r.entry_count = cnt;
        end
      end
      minv = fill ? tbl_values[0] : 0;
      maxv = fill ? tbl_values[fill-1] : 0;
      bad_first = first_val > minv;
      if (bmode) total = bad_first ? 0 : bucket_number(maxv) + 1;
      else total = fill;
      if (kind == ssh_pkg::KIND_READ) begin
        if (!bmode) begin
          if (idx < fill) begin
            r.entry_value = tbl_values[idx];
            r.entry_count = tbl_freqs[idx];
          end else begin
            r.status = ssh_pkg::ST_RANGE;
          end
        end else if (bad_first) begin
          r.status = ssh_pkg::ST_BAD_FIRST;
        end else if (longint'(idx) >= total) begin
          r.status = ssh_pkg::ST_RANGE;
        end else begin
          r.entry_value = 32'(longint'(first_val) + longint'(idx) * width_of());
          for (int i = 0; i < fill; i++)
            if (bucket_number(tbl_values[i]) == longint'(idx))
              r.entry_count = add_sat(r.entry_count, tbl_freqs[i]);
        end
      end else if (kind == ssh_pkg::KIND_QUERY) begin
        if (!bmode) begin
          if (fill == 0) r.entry_count = 1;
          for (int i = 0; i < fill; i++)
            if (tbl_freqs[i] > r.entry_count) r.entry_count = tbl_freqs[i];
        end else if (bad_first) begin
          r.status = ssh_pkg::ST_BAD_FIRST;
        end else begin
          run = 0;
          for (int i = 0; i < fill; i++) begin
            if (i > 0 && bucket_number(tbl_values[i]) != bucket_number(tbl_values[i-1]))
              run = 0;
            run = add_sat(run, tbl_freqs[i]);
            if (run > r.entry_count) r.entry_count = run;
          end
        end
      end
      r.distinct_count = fill[8:0];
      r.min_value = minv;
      r.max_value = maxv;
      r.bucket_total = total[32:0];
      pending.push_back(r);
    endfunction

    // Compares one result from the block with the oldest expectation.
    function void check_result(hist_result_t got);
      hist_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [95:0]      s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [ODP-1:0]   m_tdata;
  logic [1:0]       m_tuser;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [31:0]      cfg_data;

  histogram_scoreboard hist_sb;
  longint           cycle_count;
  bit               recv_hold;    // long hold-off by the receiver
  bit               no_idle;      // last part of the run, no idling

  sparse_sorted_histogram i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the total cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Results are sampled at the edge where both handshake signals are high.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      hist_sb.check_result('{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[72:64],
                              m_tdata[104:73], m_tdata[136:105], m_tdata[169:137]});
  end

  // The receiver stalls in random bursts, or for a long stretch on request.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (recv_hold) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one transfer and waits until the block takes it, with an optional
  // random gap before.
  task automatic send_item(logic [1:0] kind, logic [31:0] sval, logic [31:0] cnt,
                           logic [31:0] idx);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {idx, cnt, sval};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hist_sb.note_input(kind, sval, cnt, idx);
  endtask

  // Lowers valid and waits until every expected result has come.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (hist_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the enable is high for a single cycle and is low again before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hist_sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Values are drawn mostly from a narrow window so that hits and shared buckets
  // occur; some span the whole range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 120)) - 60);
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 2);
      1: return $urandom;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  task automatic random_item();
    logic [1:0] k;
    logic [31:0] idx;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: k = ssh_pkg::KIND_ADD;
      5, 6, 7: k = ssh_pkg::KIND_READ;
      8: k = ssh_pkg::KIND_QUERY;
      default: k = ssh_pkg::KIND_UNUSED;
    endcase
    idx = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
    send_item(k, pick_value(), pick_count(), idx);
  endtask

  // One register setting for a random phase.
  task automatic random_config();
    case ($urandom_range(0, 4))
      0: begin
        write_reg(ssh_pkg::REG_BUCKET_MODE, 32'd0);
      end
      1: begin
        write_reg(ssh_pkg::REG_BUCKET_MODE, 32'd1);
        write_reg(ssh_pkg::REG_FIRST_BUCKET, 32'h8000_0000);
        write_reg(ssh_pkg::REG_BUCKET_SIZE, 32'h7FFF_FFFF);
      end
      2: begin
        write_reg(ssh_pkg::REG_BUCKET_MODE, 32'd1);
        write_reg(ssh_pkg::REG_FIRST_BUCKET, 32'h8000_0000);
        write_reg(ssh_pkg::REG_BUCKET_SIZE, 32'd1 << $urandom_range(20, 30));
      end
      default: begin
        write_reg(ssh_pkg::REG_BUCKET_MODE, 32'd1);
        write_reg(ssh_pkg::REG_FIRST_BUCKET, 32'($signed($urandom_range(0, 40)) - 80));
        write_reg(ssh_pkg::REG_BUCKET_SIZE, $urandom_range(0, 16));
      end
    endcase
  endtask

  initial begin
    hist_sb = new();
    hist_sb.clear();
    cycle_count = 0;
    recv_hold = 0;
    no_idle = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty-table answers with bucket mode off, extremes of the fields,
    // hits with saturation, unused kind, out-of-range reads, zero bucket size.
    send_item(ssh_pkg::KIND_QUERY, 0, 0, 0);
    send_item(ssh_pkg::KIND_READ, 0, 0, 0);
    send_item(ssh_pkg::KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ssh_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(ssh_pkg::KIND_ADD, 32'h8000_0000, 32'd5, 0);
    send_item(ssh_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'd1, 0);
    send_item(ssh_pkg::KIND_ADD, 32'd0, 32'd0, 0);
    send_item(ssh_pkg::KIND_ADD, 32'h8000_0000, 32'hFFFF_FFFE, 0);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd2);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd3);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'hFFFF_FFFF);
    send_item(ssh_pkg::KIND_QUERY, 0, 0, 0);
    drain();
    write_reg(ssh_pkg::REG_BUCKET_MODE, 32'd1);
    write_reg(ssh_pkg::REG_FIRST_BUCKET, 32'h8000_0000);
    write_reg(ssh_pkg::REG_BUCKET_SIZE, 32'd0);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd0);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'hFFFF_FFFF);
    send_item(ssh_pkg::KIND_QUERY, 0, 0, 0);
    drain();
    write_reg(ssh_pkg::REG_BUCKET_SIZE, 32'h7FFF_FFFF);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd1);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd2);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd3);
    send_item(ssh_pkg::KIND_QUERY, 0, 0, 0);
    drain();
    // First bucket above the minimum.
    write_reg(ssh_pkg::REG_FIRST_BUCKET, 32'h7FFF_FFFF);
    send_item(ssh_pkg::KIND_READ, 0, 0, 32'd0);
    send_item(ssh_pkg::KIND_QUERY, 0, 0, 0);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 9; ph++) begin
      random_config();
      if (ph == 2) begin
        // The receiver holds off for a long stretch while the sender keeps
        // offering transfers, so the block fills up and stalls its input.
        fork
          begin
            recv_hold = 1;
            repeat (3000) @(posedge clk);
            recv_hold = 0;
          end
          repeat (8) random_item();
        join
      end
      if (ph == 5) begin
        // Fill the table to capacity so that new values report full.
        for (int n = 0; n < 270; n++)
          send_item(ssh_pkg::KIND_ADD, 32'($signed(n * 3) - 400), $urandom_range(0, 9), 0);
      end
      if (ph == 8) no_idle = 1;
      repeat (20) random_item();
      drain();
    end

    repeat (200) @(posedge clk);
    if (hist_sb.mismatches == 0 && hist_sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
design/ssh_pkg.sv
design/sparse_sorted_histogram.sv
test/tb_sparse_sorted_histogram.sv
